### src/ccts_pkg.sv
// Package of the compartment chain trapezoid stepper: widths, codes, payload types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ccts_pkg;

  localparam int VALUE_WIDTH    = 48;
  localparam int MAX_STAGES_DEF = 16;
  localparam int RATE_WIDTH     = 32;
  localparam int STAGE_WIDTH    = 5;
  localparam int SLOT_WIDTH     = 6;
  localparam int POP_WIDTH      = 48;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int COEF_WIDTH     = 40;
  localparam int NUM_WIDTH      = VALUE_WIDTH + 42;
  localparam int QUO_WIDTH      = VALUE_WIDTH + 1;
  localparam int MUL_A_WIDTH    = VALUE_WIDTH + 1;
  localparam int SUMSQ_WIDTH    = 2 * VALUE_WIDTH + 8;
  localparam int PROD_WIDTH     = MUL_A_WIDTH + SUMSQ_WIDTH;
  localparam int FRAC_SHIFT     = 29;
  localparam int TOL_SHIFT      = 28;

  localparam logic signed [COEF_WIDTH-1:0] ONE_Q =
    {{(COEF_WIDTH-FRAC_SHIFT-1){1'b0}}, 1'b1, {FRAC_SHIFT{1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD, OP_FORWARD, OP_BACKWARD, OP_PASS_END
  } opcode_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_LATENT_RATE, CFG_INFECTIOUS_RATE, CFG_REMOVAL_RATE,
    CFG_LATENT_STAGES, CFG_INFECTIOUS_STAGES, CFG_TOLERANCE_SQ
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD_PUT,
    ST_STEP_RD, ST_STEP_MUL, ST_STEP_MUL_WAIT, ST_STEP_DIV, ST_STEP_DIV_WAIT,
    ST_STEP_SAT, ST_STEP_FLOW, ST_STEP_FLOW_WAIT,
    ST_PASS_RD, ST_PASS_DIFF, ST_PASS_DIFF_WAIT, ST_PASS_SNAP, ST_PASS_SNAP_WAIT,
    ST_PASS_TOL, ST_PASS_TOL_WAIT,
    ST_EMIT_RD, ST_EMIT_PUT
  } state_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [SLOT_WIDTH-1:0]   slot;
    logic [POP_WIDTH-1:0]    load_value;
    logic [POP_WIDTH-1:0]    incidence;
    logic [POP_WIDTH-1:0]    births;
    logic [RATE_WIDTH-1:0]   mortality_earlier;
    logic [RATE_WIDTH-1:0]   mortality_later;
  } in_t;

  typedef struct packed {
    logic [SLOT_WIDTH-1:0]          out_slot;
    logic signed [VALUE_WIDTH-1:0]  out_value;
    logic                           converged;
    logic                           overflow;
    logic                           last;
  } out_t;

endpackage

`default_nettype wire

### src/ccts_mul.sv
// Shared shift-add multiplier of the stepper, one multiplier bit per cycle.
// Depends on ccts_pkg for operand widths.
`default_nettype none

module ccts_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ccts_pkg::MUL_A_WIDTH-1:0]    a,
  input  logic [ccts_pkg::SUMSQ_WIDTH-1:0]    b,
  output logic                                busy,
  output logic [ccts_pkg::PROD_WIDTH-1:0]     product
);

  localparam int AW = ccts_pkg::MUL_A_WIDTH;
  localparam int BW = ccts_pkg::SUMSQ_WIDTH;
  localparam int CW = $clog2(AW + 1);

  logic [BW-1:0] mcand;
  logic [BW-1:0] hi;
  logic [AW-1:0] lo;
  logic [CW-1:0] count;
  logic [BW:0]   sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(BW+1){1'b0}});
  assign busy    = (count != '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(AW);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= b;
      hi    <= '0;
      lo    <= a;
    end else if (busy) begin
      hi <= sum[BW:1];
      lo <= {sum[0], lo[AW-1:1]};
    end
  end

endmodule

`default_nettype wire

### src/ccts_div.sv
// Shared restoring divider of the stepper, one quotient bit per cycle.
// Flags a quotient that cannot fit before iterating; depends on ccts_pkg.
`default_nettype none

module ccts_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ccts_pkg::NUM_WIDTH-1:0]     num,
  input  logic [ccts_pkg::COEF_WIDTH-1:0]    den,
  output logic                               busy,
  output logic                               big,
  output logic [ccts_pkg::QUO_WIDTH-1:0]     quotient
);

  localparam int NW = ccts_pkg::NUM_WIDTH;
  localparam int DW = ccts_pkg::COEF_WIDTH;
  localparam int QW = ccts_pkg::QUO_WIDTH;
  localparam int TW = NW - QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] lo;
  logic [CW-1:0] count;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial    = {rem, lo[QW-1]};
  assign diff     = trial - {1'b0, dreg};
  assign fits     = (trial >= {1'b0, dreg});
  assign busy     = (count != '0);
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(QW);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= den;
      big  <= (num[NW-1:QW] >= TW'(den));
      rem  <= DW'(num[NW-1:QW]);
      lo   <= num[QW-1:0];
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      lo  <= {lo[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### src/compartment_chain_trapezoid_stepper.sv
// Top level of the compartment chain trapezoid stepper: sequencer, stores, output register.
// Depends on ccts_pkg, ccts_mul and ccts_div.
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+--------------------------
//  in      | in_valid, in_stall, in_data   | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data| out_valid && !out_stall
//  cfg     | cfg_write, cfg_index, cfg_data| cfg_write
//
// N = L + I + 2 compartments. Load: one store write and one result. Step: per stage
// read, multiply, divide, saturate and flow multiply; S without flow; then N results.
// Pass end: difference and snapshot squared per compartment; tolerance test; N results.
// Synchronous reset clears the stores through per-entry valid bits at once.
// A stalled output holds the sequencer; the next item enters while the last result waits.
`default_nettype none

module compartment_chain_trapezoid_stepper #(
  parameter int MAX_STAGES = ccts_pkg::MAX_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ccts_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ccts_pkg::out_t                      out_data,
  input  logic                                cfg_write,
  input  logic [ccts_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [ccts_pkg::RATE_WIDTH-1:0]     cfg_data
);

  localparam int DEPTH = 2 * MAX_STAGES + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int V     = ccts_pkg::VALUE_WIDTH;
  localparam int CW    = ccts_pkg::COEF_WIDTH;
  localparam int NW    = ccts_pkg::NUM_WIDTH;
  localparam int QW    = ccts_pkg::QUO_WIDTH;
  localparam int MA    = ccts_pkg::MUL_A_WIDTH;
  localparam int SW    = ccts_pkg::SUMSQ_WIDTH;
  localparam int PW    = ccts_pkg::PROD_WIDTH;
  localparam int RW    = ccts_pkg::RATE_WIDTH;
  localparam int STW   = ccts_pkg::STAGE_WIDTH;
  localparam int SLW   = ccts_pkg::SLOT_WIDTH;
  localparam int PPW   = ccts_pkg::POP_WIDTH;
  localparam int FS    = ccts_pkg::FRAC_SHIFT;
  localparam int TS    = ccts_pkg::TOL_SHIFT;

  localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
  localparam logic [STW-1:0]      MAX_ST = STW'(MAX_STAGES);
  localparam logic [QW-1:0]       LIM_POS = QW'(VMAX);
  localparam logic [QW-1:0]       LIM_NEG = QW'(VMAX) + 1'b1;

  // configuration
  logic [RW-1:0]  latent_rate, infectious_rate, removal_rate, tolerance_squared;
  logic [STW-1:0] latent_stages, infectious_stages;

  always_ff @(posedge clk) begin
    if (rst) begin
      latent_rate       <= '0;
      infectious_rate   <= '0;
      removal_rate      <= '0;
      latent_stages     <= STW'(1);
      infectious_stages <= STW'(1);
      tolerance_squared <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ccts_pkg::CFG_LATENT_RATE:       latent_rate       <= cfg_data;
        ccts_pkg::CFG_INFECTIOUS_RATE:   infectious_rate   <= cfg_data;
        ccts_pkg::CFG_REMOVAL_RATE:      removal_rate      <= cfg_data;
        ccts_pkg::CFG_LATENT_STAGES:     latent_stages     <= cfg_data[STW-1:0];
        ccts_pkg::CFG_INFECTIOUS_STAGES: infectious_stages <= cfg_data[STW-1:0];
        ccts_pkg::CFG_TOLERANCE_SQ:      tolerance_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [STW-1:0]    nl, ni;
  logic [STW+1:0]    top;
  logic [RW+STW-1:0] hs, hg;

  assign nl  = (latent_stages > MAX_ST) ? MAX_ST : latent_stages;
  assign ni  = (infectious_stages > MAX_ST) ? MAX_ST : infectious_stages;
  assign top = {2'b00, nl} + {2'b00, ni} + 1'b1;
  assign hs  = latent_rate * nl;
  assign hg  = infectious_rate * ni;

  // sequencer registers
  ccts_pkg::state_t state, state_next;
  ccts_pkg::in_t    item;
  logic [AW-1:0]          k;
  logic signed [NW-1:0]   in_acc;
  logic signed [V-1:0]    old_v, new_v;
  logic [V-1:0]           snap_mag;
  logic [SW-1:0]          num_acc, den_acc;
  logic                   num_neg, num_zero, den_neg, den_zero, flow_neg;
  logic                   ov, conv;

  // stores
  logic signed [V-1:0] run_mem [DEPTH];
  logic signed [V-1:0] snp_mem [DEPTH];
  logic [DEPTH-1:0]    run_vld, snp_vld;
  logic signed [V-1:0] rd_run, rd_snp;
  logic                rd_run_ok, rd_snp_ok;
  logic signed [V-1:0] run_val, snp_val;

  logic                run_we, snp_we;
  logic [AW-1:0]       wr_addr;
  logic signed [V-1:0] run_wd, snp_wd;

  assign run_val = rd_run_ok ? rd_run : '0;
  assign snp_val = rd_snp_ok ? rd_snp : '0;

  always_ff @(posedge clk) begin
    rd_run    <= run_mem[k];
    rd_snp    <= snp_mem[k];
    rd_run_ok <= run_vld[k];
    rd_snp_ok <= snp_vld[k];
    if (run_we) begin
      run_mem[wr_addr] <= run_wd;
    end
    if (snp_we) begin
      snp_mem[wr_addr] <= snp_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_vld <= '0;
      snp_vld <= '0;
    end else begin
      if (run_we) begin
        run_vld[wr_addr] <= 1'b1;
      end
      if (snp_we) begin
        snp_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // shared units
  logic          mul_start, mul_busy;
  logic [MA-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_busy, div_big;
  logic [NW-1:0] div_num;
  logic [CW-1:0] div_den;
  logic [QW-1:0] div_quo;

  ccts_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  ccts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .big      (div_big),
    .quotient (div_quo)
  );

  // step datapath
  logic                 fwd;
  logic [STW+1:0]       kx;
  logic signed [CW-1:0] h, w0, w1, coef, dvs;
  logic                 coef_neg;
  logic [CW-1:0]        coef_mag, dvs_mag;
  logic [V-1:0]         old_mag;
  logic signed [NW-1:0] p_s, num_s, flow_s, z45_in, z45, b45;
  logic [NW-1:0]        num_mag;
  logic signed [V:0]    flow_sum, diff;
  logic [V:0]           flow_mag, diff_mag;
  logic                 q_neg, sat_ov;
  logic signed [V-1:0]  sat_val;
  logic                 slot_ok, load_ov;
  logic signed [V-1:0]  load_val;
  logic                 out_free, out_load, k_last;
  ccts_pkg::out_t       out_next;

  assign fwd      = (item.opcode == ccts_pkg::OP_FORWARD);
  assign kx       = (STW+2)'(k);
  assign k_last   = (kx == top);
  assign h        = (k == '0) ? '0 :
                    (kx <= {2'b00, nl}) ? $signed(CW'(hs)) :
                    (kx <= {2'b00, nl} + {2'b00, ni}) ? $signed(CW'(hg)) :
                    $signed(CW'(removal_rate));
  assign w0       = ccts_pkg::ONE_Q - $signed(CW'(item.mortality_earlier));
  assign w1       = ccts_pkg::ONE_Q + $signed(CW'(item.mortality_later));
  assign coef     = fwd ? (w0 - h) : (w1 + h);
  assign dvs      = fwd ? (w1 + h) : (w0 - h);
  assign coef_neg = coef[CW-1];
  assign coef_mag = coef_neg ? CW'(-coef) : CW'(coef);
  assign dvs_mag  = dvs[CW-1] ? CW'(-dvs) : CW'(dvs);
  assign old_mag  = run_val[V-1] ? V'(-run_val) : V'(run_val);

  assign p_s      = (coef_neg ^ old_v[V-1]) ? -$signed(mul_prod[NW-1:0])
                                            : $signed(mul_prod[NW-1:0]);
  assign num_s    = p_s + (fwd ? in_acc : -in_acc);
  assign num_mag  = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);

  assign flow_sum = {old_v[V-1], old_v} + {new_v[V-1], new_v};
  assign flow_mag = flow_sum[V] ? (V+1)'(-flow_sum) : (V+1)'(flow_sum);
  assign flow_s   = flow_neg ? -$signed(mul_prod[NW-1:0]) : $signed(mul_prod[NW-1:0]);
  assign z45_in   = $signed(NW'({in_data.incidence, {FS{1'b0}}}));
  assign z45      = $signed(NW'({item.incidence, {FS{1'b0}}}));
  assign b45      = $signed(NW'({item.births, {FS{1'b0}}}));

  assign diff     = {run_val[V-1], run_val} - {snp_val[V-1], snp_val};
  assign diff_mag = diff[V] ? (V+1)'(-diff) : (V+1)'(diff);

  assign q_neg = num_neg ^ den_neg;

  always_comb begin
    sat_ov  = 1'b0;
    sat_val = '0;
    if (den_zero) begin
      sat_ov  = 1'b1;
      sat_val = num_zero ? '0 : (num_neg ? VMIN : VMAX);
    end else if (div_big || div_quo > (q_neg ? LIM_NEG : LIM_POS)) begin
      sat_ov  = 1'b1;
      sat_val = q_neg ? VMIN : VMAX;
    end else begin
      sat_val = q_neg ? -$signed(div_quo[V-1:0]) : $signed(div_quo[V-1:0]);
    end
  end

  assign slot_ok  = ({1'b0, item.slot} < (SLW+1)'(DEPTH));
  assign load_ov  = slot_ok && (item.load_value > PPW'(VMAX));
  assign load_val = !slot_ok ? '0 : (load_ov ? VMAX : $signed(V'(item.load_value)));
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ccts_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            ccts_pkg::OP_LOAD:     state_next = ccts_pkg::ST_LOAD_PUT;
            ccts_pkg::OP_PASS_END: state_next = ccts_pkg::ST_PASS_RD;
            default:               state_next = ccts_pkg::ST_STEP_RD;
          endcase
        end
      end
      ccts_pkg::ST_LOAD_PUT:       if (out_free) state_next = ccts_pkg::ST_IDLE;
      ccts_pkg::ST_STEP_RD:        state_next = ccts_pkg::ST_STEP_MUL;
      ccts_pkg::ST_STEP_MUL:       state_next = ccts_pkg::ST_STEP_MUL_WAIT;
      ccts_pkg::ST_STEP_MUL_WAIT:  if (!mul_busy) state_next = ccts_pkg::ST_STEP_DIV;
      ccts_pkg::ST_STEP_DIV:       state_next = ccts_pkg::ST_STEP_DIV_WAIT;
      ccts_pkg::ST_STEP_DIV_WAIT:  if (!div_busy) state_next = ccts_pkg::ST_STEP_SAT;
      ccts_pkg::ST_STEP_SAT: begin
        state_next = (k == '0) ? ccts_pkg::ST_EMIT_RD : ccts_pkg::ST_STEP_FLOW;
      end
      ccts_pkg::ST_STEP_FLOW:      state_next = ccts_pkg::ST_STEP_FLOW_WAIT;
      ccts_pkg::ST_STEP_FLOW_WAIT: if (!mul_busy) state_next = ccts_pkg::ST_STEP_RD;
      ccts_pkg::ST_PASS_RD:        state_next = ccts_pkg::ST_PASS_DIFF;
      ccts_pkg::ST_PASS_DIFF:      state_next = ccts_pkg::ST_PASS_DIFF_WAIT;
      ccts_pkg::ST_PASS_DIFF_WAIT: if (!mul_busy) state_next = ccts_pkg::ST_PASS_SNAP;
      ccts_pkg::ST_PASS_SNAP:      state_next = ccts_pkg::ST_PASS_SNAP_WAIT;
      ccts_pkg::ST_PASS_SNAP_WAIT: begin
        if (!mul_busy) begin
          state_next = k_last ? ccts_pkg::ST_PASS_TOL : ccts_pkg::ST_PASS_RD;
        end
      end
      ccts_pkg::ST_PASS_TOL:       state_next = ccts_pkg::ST_PASS_TOL_WAIT;
      ccts_pkg::ST_PASS_TOL_WAIT:  if (!mul_busy) state_next = ccts_pkg::ST_EMIT_RD;
      ccts_pkg::ST_EMIT_RD:        state_next = ccts_pkg::ST_EMIT_PUT;
      ccts_pkg::ST_EMIT_PUT: begin
        if (out_free) begin
          state_next = k_last ? ccts_pkg::ST_IDLE : ccts_pkg::ST_EMIT_RD;
        end
      end
      default:                     state_next = ccts_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = num_mag;
    div_den   = dvs_mag;
    run_we    = 1'b0;
    snp_we    = 1'b0;
    wr_addr   = k;
    run_wd    = sat_val;
    snp_wd    = run_val;
    out_load  = 1'b0;
    out_next  = '{out_slot: SLW'(k), out_value: run_val, converged: conv,
                  overflow: ov, last: k_last};
    case (state)
      ccts_pkg::ST_IDLE: in_stall = 1'b0;
      ccts_pkg::ST_LOAD_PUT: begin
        wr_addr  = item.slot[AW-1:0];
        run_we   = slot_ok;
        snp_we   = slot_ok;
        run_wd   = load_val;
        snp_wd   = load_val;
        out_load = out_free;
        out_next = '{out_slot: item.slot, out_value: load_val, converged: 1'b0,
                     overflow: load_ov, last: 1'b1};
      end
      ccts_pkg::ST_STEP_MUL: begin
        mul_start = 1'b1;
        mul_a     = MA'(coef_mag);
        mul_b     = SW'(old_mag);
      end
      ccts_pkg::ST_STEP_DIV:  div_start = 1'b1;
      ccts_pkg::ST_STEP_SAT:  run_we = 1'b1;
      ccts_pkg::ST_STEP_FLOW: begin
        mul_start = 1'b1;
        mul_a     = MA'(h);
        mul_b     = SW'(flow_mag);
      end
      ccts_pkg::ST_PASS_DIFF: begin
        mul_start = 1'b1;
        mul_a     = MA'(diff_mag);
        mul_b     = SW'(diff_mag);
        snp_we    = 1'b1;
      end
      ccts_pkg::ST_PASS_SNAP: begin
        mul_start = 1'b1;
        mul_a     = MA'(snap_mag);
        mul_b     = SW'(snap_mag);
      end
      ccts_pkg::ST_PASS_TOL: begin
        mul_start = 1'b1;
        mul_a     = MA'(tolerance_squared);
        mul_b     = den_acc;
      end
      ccts_pkg::ST_EMIT_PUT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ccts_pkg::ST_IDLE: begin
        if (in_valid) begin
          item    <= in_data;
          k       <= (in_data.opcode == ccts_pkg::OP_PASS_END ||
                      in_data.opcode == ccts_pkg::OP_LOAD) ? AW'(0) : AW'(1);
          in_acc  <= z45_in;
          num_acc <= '0;
          den_acc <= '0;
          ov      <= 1'b0;
          conv    <= 1'b0;
        end
      end
      ccts_pkg::ST_STEP_MUL: old_v <= run_val;
      ccts_pkg::ST_STEP_DIV: begin
        num_neg  <= num_s[NW-1];
        num_zero <= (num_s == '0);
        den_neg  <= dvs[CW-1];
        den_zero <= (dvs == '0);
      end
      ccts_pkg::ST_STEP_SAT: begin
        new_v <= sat_val;
        ov    <= ov | sat_ov;
      end
      ccts_pkg::ST_STEP_FLOW: flow_neg <= flow_sum[V];
      ccts_pkg::ST_STEP_FLOW_WAIT: begin
        if (!mul_busy) begin
          if (k_last) begin
            in_acc <= flow_s - z45 + b45;
            k      <= '0;
          end else begin
            in_acc <= flow_s;
            k      <= k + 1'b1;
          end
        end
      end
      ccts_pkg::ST_PASS_DIFF: snap_mag <= snp_val[V-1] ? V'(-snp_val) : V'(snp_val);
      ccts_pkg::ST_PASS_DIFF_WAIT: begin
        if (!mul_busy) begin
          num_acc <= num_acc + mul_prod[SW-1:0];
        end
      end
      ccts_pkg::ST_PASS_SNAP_WAIT: begin
        if (!mul_busy) begin
          den_acc <= den_acc + mul_prod[SW-1:0];
          if (!k_last) begin
            k <= k + 1'b1;
          end
        end
      end
      ccts_pkg::ST_PASS_TOL_WAIT: begin
        if (!mul_busy) begin
          conv <= (den_acc == '0) || (PW'({num_acc, {TS{1'b0}}}) < mul_prod);
          k    <= '0;
        end
      end
      ccts_pkg::ST_EMIT_PUT: begin
        if (out_free && !k_last) begin
          k <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_mul_start_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    (state == ccts_pkg::ST_IDLE) |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit busy while idle");
  a_both_stores: assert property (@(posedge clk) disable iff (rst)
    (run_we && snp_we) |-> (state == ccts_pkg::ST_LOAD_PUT))
    else $error("both stores written outside a load");
`endif

endmodule

`default_nettype wire

### dv/ccts_checker.sv
// Checker of the compartment chain trapezoid stepper: watches the input, output and
// register ports, predicts every result and compares. Depends on ccts_pkg.
`timescale 1ns / 1ps

module ccts_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  ccts_pkg::in_t                      in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  ccts_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [ccts_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [ccts_pkg::RATE_WIDTH-1:0]    cfg_data,
  output int                                 failures,
  output int                                 pending
);

  localparam int VW    = ccts_pkg::VALUE_WIDTH;
  localparam int MXS   = ccts_pkg::MAX_STAGES_DEF;
  localparam int DEPTH = 2 * MXS + 2;
  localparam logic signed [191:0] VMAX_W = (192'sd1 <<< (VW - 1)) - 1;
  localparam logic signed [191:0] VMIN_W = -(192'sd1 <<< (VW - 1));

  logic signed [VW-1:0] chain [DEPTH];
  logic signed [VW-1:0] snap [DEPTH];
  logic [ccts_pkg::RATE_WIDTH-1:0] lat_rate, inf_rate, rem_rate, tol_sq;
  logic [ccts_pkg::STAGE_WIDTH-1:0] lat_n, inf_n;
  ccts_pkg::out_t results_due [$];

  function automatic int clamp_stages(input logic [ccts_pkg::STAGE_WIDTH-1:0] n);
    return (n > MXS) ? MXS : int'(n);
  endfunction

  function automatic logic signed [VW-1:0] quot(input logic signed [191:0] n,
                                                input logic signed [191:0] d,
                                                inout logic ov);
    logic signed [191:0] q;
    if (d == 0) begin
      ov = 1'b1;
      if (n == 0) return '0;
      return (n < 0) ? VMIN_W[VW-1:0] : VMAX_W[VW-1:0];
    end
    q = n / d;
    if (q > VMAX_W) begin
      ov = 1'b1;
      return VMAX_W[VW-1:0];
    end
    if (q < VMIN_W) begin
      ov = 1'b1;
      return VMIN_W[VW-1:0];
    end
    return q[VW-1:0];
  endfunction

  task automatic advance_chain(input logic backward, input ccts_pkg::in_t it,
                               inout logic ov);
    int nl, ni;
    logic signed [191:0] w0, w1, hs, hg, hd, h, z45, b45, inflow, old, nw, s;
    nl = clamp_stages(lat_n);
    ni = clamp_stages(inf_n);
    w0 = (192'sd1 <<< ccts_pkg::FRAC_SHIFT) - $signed({160'd0, it.mortality_earlier});
    w1 = (192'sd1 <<< ccts_pkg::FRAC_SHIFT) + $signed({160'd0, it.mortality_later});
    hs = $signed({160'd0, lat_rate}) * nl;
    hg = $signed({160'd0, inf_rate}) * ni;
    hd = $signed({160'd0, rem_rate});
    z45 = $signed({144'd0, it.incidence}) <<< ccts_pkg::FRAC_SHIFT;
    b45 = $signed({144'd0, it.births}) <<< ccts_pkg::FRAC_SHIFT;
    inflow = z45;
    for (int k = 1; k <= nl + ni + 1; k++) begin
      h = (k <= nl) ? hs : ((k <= nl + ni) ? hg : hd);
      old = chain[k];
      if (!backward) nw = quot((w0 - h) * old + inflow, w1 + h, ov);
      else nw = quot((w1 + h) * old - inflow, w0 - h, ov);
      nw = $signed(nw[VW-1:0]);
      inflow = h * (old + nw);
      chain[k] = nw[VW-1:0];
    end
    inflow = inflow - z45 + b45;
    s = chain[0];
    if (!backward) chain[0] = quot(w0 * s + inflow, w1, ov);
    else chain[0] = quot(w1 * s - inflow, w0, ov);
  endtask

  task automatic predict_results(input ccts_pkg::in_t it);
    int cnt;
    logic ov, conv;
    logic signed [VW-1:0] v;
    logic signed [255:0] num, den, diff, sv;
    ccts_pkg::out_t r;
    cnt = clamp_stages(lat_n) + clamp_stages(inf_n) + 2;
    ov = 1'b0;
    conv = 1'b0;
    if (it.opcode == ccts_pkg::OP_LOAD) begin
      v = '0;
      if (it.slot < DEPTH) begin
        if (it.load_value > VMAX_W[VW-1:0]) begin
          v = VMAX_W[VW-1:0];
          ov = 1'b1;
        end else begin
          v = it.load_value;
        end
        chain[it.slot] = v;
        snap[it.slot] = v;
      end
      r = '{out_slot: it.slot, out_value: v, converged: 1'b0, overflow: ov, last: 1'b1};
      results_due.push_back(r);
      return;
    end
    if (it.opcode == ccts_pkg::OP_PASS_END) begin
      num = '0;
      den = '0;
      for (int k = 0; k < cnt; k++) begin
        diff = chain[k];
        diff = diff - snap[k];
        sv = snap[k];
        num = num + diff * diff;
        den = den + sv * sv;
        snap[k] = chain[k];
      end
      conv = (den == 0) ||
             ((num <<< ccts_pkg::TOL_SHIFT) < $signed({224'd0, tol_sq}) * den);
    end else begin
      advance_chain(it.opcode == ccts_pkg::OP_BACKWARD, it, ov);
    end
    for (int k = 0; k < cnt; k++) begin
      r = '{out_slot: k[ccts_pkg::SLOT_WIDTH-1:0], out_value: chain[k], converged: conv,
            overflow: ov, last: (k == cnt - 1)};
      results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    ccts_pkg::out_t e;
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        chain[k] = '0;
        snap[k] = '0;
      end
      lat_rate = '0;
      inf_rate = '0;
      rem_rate = '0;
      tol_sq = '0;
      lat_n = 5'd1;
      inf_n = 5'd1;
      results_due.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: slot %0d value %0d", out_data.out_slot,
                 out_data.out_value);
          failures <= failures + 1;
        end else begin
          e = results_due.pop_front();
          if (out_data !== e) failures <= failures + 1;
          if (out_data.out_slot !== e.out_slot)
            $error("out_slot: expected %0d, actual %0d", e.out_slot, out_data.out_slot);
          if (out_data.out_value !== e.out_value)
            $error("out_value: expected %0d, actual %0d", e.out_value, out_data.out_value);
          if (out_data.converged !== e.converged)
            $error("converged: expected %0b, actual %0b", e.converged, out_data.converged);
          if (out_data.overflow !== e.overflow)
            $error("overflow: expected %0b, actual %0b", e.overflow, out_data.overflow);
          if (out_data.last !== e.last)
            $error("last: expected %0b, actual %0b", e.last, out_data.last);
        end
      end
      if (cfg_write) begin
        case (ccts_pkg::cfg_index_t'(cfg_index))
          ccts_pkg::CFG_LATENT_RATE:       lat_rate = cfg_data;
          ccts_pkg::CFG_INFECTIOUS_RATE:   inf_rate = cfg_data;
          ccts_pkg::CFG_REMOVAL_RATE:      rem_rate = cfg_data;
          ccts_pkg::CFG_LATENT_STAGES:     lat_n = cfg_data[ccts_pkg::STAGE_WIDTH-1:0];
          ccts_pkg::CFG_INFECTIOUS_STAGES: inf_n = cfg_data[ccts_pkg::STAGE_WIDTH-1:0];
          ccts_pkg::CFG_TOLERANCE_SQ:      tol_sq = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_results(in_data);
      pending <= results_due.size();
    end
  end

endmodule

### dv/compartment_chain_trapezoid_stepper_tb.sv
// Testbench top of the compartment chain trapezoid stepper: clock, reset, register
// writes, stimulus and verdict. Depends on ccts_pkg, the block and ccts_checker.
`timescale 1ns / 1ps

module compartment_chain_trapezoid_stepper_tb;

  localparam int PW = ccts_pkg::POP_WIDTH;
  localparam int RW = ccts_pkg::RATE_WIDTH;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  ccts_pkg::in_t in_data;
  ccts_pkg::out_t out_data;
  logic cfg_write;
  logic [ccts_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
  logic [RW-1:0] cfg_data;
  int failures, pending;
  bit sending;
  int burst_left;
  int stall_mode, stall_timer;

  compartment_chain_trapezoid_stepper i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ccts_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic logic [PW-1:0] rand_pop();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[PW-1:0] >> $urandom_range(0, 47);
  endfunction

  function automatic logic [RW-1:0] rand_rate();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic ccts_pkg::in_t item(ccts_pkg::opcode_t op, int slot,
                                         logic [PW-1:0] lv, logic [PW-1:0] z,
                                         logic [PW-1:0] b, logic [RW-1:0] me,
                                         logic [RW-1:0] ml);
    return '{opcode: op, slot: slot[ccts_pkg::SLOT_WIDTH-1:0], load_value: lv,
             incidence: z, births: b, mortality_earlier: me, mortality_later: ml};
  endfunction

  function automatic ccts_pkg::in_t rand_item(ccts_pkg::opcode_t op, int slot_hi);
    return item(op, $urandom_range(0, slot_hi), rand_pop(), rand_pop(), rand_pop(),
                rand_rate(), rand_rate());
  endfunction

  task automatic put(input ccts_pkg::in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    sending = 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] lr, logic [31:0] ir, logic [31:0] rr,
                       logic [31:0] ls, logic [31:0] is, logic [31:0] tol);
    logic [31:0] vals [6];
    vals = '{lr, ir, rr, ls, is, tol};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[ccts_pkg::CFG_IDX_WIDTH-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count, int ls, int is);
    int n;
    n = ls + is + 2;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put(rand_item(ccts_pkg::OP_LOAD, ($urandom_range(0, 9) == 0) ? 63 : n - 1));
        3, 4, 5: put(rand_item(ccts_pkg::OP_FORWARD, 0));
        6, 7: put(rand_item(ccts_pkg::OP_BACKWARD, 0));
        default: put(rand_item(ccts_pkg::OP_PASS_END, 0));
      endcase
    end
    drain();
  endtask

  initial begin
    int ls, is;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    out_stall <= 1'b0;
    stall_mode = 0;
    stall_timer = 0;
    burst_left = 0;
    sending = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 0, 48'd1000 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 1, 48'd10 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 2, 48'd5 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 3, '1, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 63, 48'd77, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 33, 48'd123, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_FORWARD, 0, 0, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_FORWARD, 0, 0, '1, '1, '1, '1));
    put(item(ccts_pkg::OP_BACKWARD, 0, 0, 48'd3 << 16, 48'd1 << 16, 32'h2000_0000,
             32'h100));
    put(item(ccts_pkg::OP_BACKWARD, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 3, 0, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    drain();

    setup(32'h0200_0000, 32'h0100_0000, 32'h0080_0000, 0, 0, 32'hFFFF_FFFF);
    put(item(ccts_pkg::OP_LOAD, 0, 48'd500 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_LOAD, 1, 48'd40 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_FORWARD, 0, 0, 48'd2 << 16, 48'd1 << 16, 32'h0010_0000,
             32'h0010_0000));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    drain();

    setup('1, '1, '1, 16, 16, 0);
    put(item(ccts_pkg::OP_LOAD, 33, 48'd9 << 16, 0, 0, 0, 0));
    put(item(ccts_pkg::OP_FORWARD, 0, 0, '1, 0, 0, '1));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    drain();

    setup(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 31, 20, 32'h0000_1000);
    put(item(ccts_pkg::OP_BACKWARD, 0, 0, 48'd1 << 16, 48'd1 << 16, 32'h0004_0000,
             32'h0004_0000));
    put(item(ccts_pkg::OP_PASS_END, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < 5; p++) begin
      ls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
      is = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
      setup(rand_rate(), rand_rate(), rand_rate(), ls, is, rand_rate());
      for (int k = 0; k < ls + is + 2; k++) put(item(ccts_pkg::OP_LOAD, k, rand_pop(),
                                                     0, 0, 0, 0));
      random_phase(45, ls, is);
    end

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
